// File: rtl/sparse_set_table_assert.svh
// Assertion macros used by the sparse set table sequencer (sst_ctrl).
`ifndef SPARSE_SET_TABLE_ASSERT_SVH
`define SPARSE_SET_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SST_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sparse set table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SST_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sparse set table: next-cycle check failed");

`endif

// File: rtl/sst_pkg.sv
// Package with the request and response types and codes of the sparse set table.
package sst_pkg;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 10;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [DATA_W-1:0]   data_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

endpackage

// File: rtl/sst_ram.sv
// Single-port synchronous RAM with a registered read port.
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/sst_ctrl.sv
// Sequencer that reads, modifies and writes back the slot map and the dense store.
module sst_ctrl #(
  parameter int ID_SPACE  = 1024,
  parameter int CAPACITY  = 256,
  parameter int DATA_BITS = 32,
  parameter int MAP_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  sst_pkg::req_t                req,
  input  logic                         out_free,
  output logic                         res_valid,
  output sst_pkg::rsp_t                res,
  output logic                         map_we,
  output logic                         map_re,
  output logic [$clog2(MAP_DEPTH)-1:0] map_addr,
  output logic [$clog2(CAPACITY):0]    map_wdata,
  input  logic [$clog2(CAPACITY):0]    map_rdata,
  output logic                         dense_we,
  output logic                         dense_re,
  output logic [$clog2(CAPACITY)-1:0]  dense_addr,
  output logic [$clog2(MAP_DEPTH)+DATA_BITS-1:0] dense_wdata,
  input  logic [$clog2(MAP_DEPTH)+DATA_BITS-1:0] dense_rdata
);
  import sst_pkg::*;

  `include "sparse_set_table_assert.svh"

  localparam int MAP_AW = $clog2(MAP_DEPTH);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_DENSE = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [MAP_AW-1:0]   clr_idx, clr_idx_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [FUNC_W-1:0]   op, op_next;
  logic [ID_W-1:0]     id_q, id_q_next;
  logic [DATA_BITS-1:0] data_q, data_q_next;
  logic [SLOT_W-1:0]   hole, hole_next;

  logic                map_valid;
  logic [SLOT_W-1:0]   map_slot;
  logic                in_range;
  logic                present;
  logic                full;
  logic [SLOT_W-1:0]   last;
  logic [MAP_AW-1:0]   moved_id;
  logic [DATA_BITS-1:0] moved_data;
  logic                add_fire;
  logic                rem_fire;

  assign map_valid  = map_rdata[SLOT_W];
  assign map_slot   = map_rdata[SLOT_W-1:0];
  assign in_range   = 32'(id_q) < ID_SPACE;
  assign present    = in_range && map_valid && (CNT_W'(map_slot) < count);
  assign full       = count >= CNT_W'(CAPACITY);
  assign last       = SLOT_W'(count - 1'b1);
  assign moved_id   = dense_rdata[MAP_AW+DATA_BITS-1:DATA_BITS];
  assign moved_data = dense_rdata[DATA_BITS-1:0];
  assign req_ready  = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    count_next   = count;
    op_next      = op;
    id_q_next    = id_q;
    data_q_next  = data_q;
    hole_next    = hole;
    map_we       = 1'b0;
    map_re       = 1'b0;
    map_addr     = id_q[MAP_AW-1:0];
    map_wdata    = '0;
    dense_we     = 1'b0;
    dense_re     = 1'b0;
    dense_addr   = map_slot;
    dense_wdata  = {id_q[MAP_AW-1:0], data_q};
    res_valid    = 1'b0;
    res.found    = present;
    res.data_out = '0;
    res.status   = STATUS_OK;
    res.count    = COUNT_W'(count);
    add_fire     = 1'b0;
    rem_fire     = 1'b0;

    case (state)
      S_CLEAR: begin
        map_we       = 1'b1;
        map_addr     = clr_idx;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == MAP_AW'(MAP_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        map_addr = req.id[MAP_AW-1:0];
        if (req_valid) begin
          map_re      = 1'b1;
          op_next     = req.func;
          id_q_next   = req.id;
          data_q_next = DATA_BITS'(req.data_in);
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        case (op)
          FUNC_LOOKUP: begin
            if (present) begin
              dense_re   = 1'b1;
              state_next = S_DENSE;
            end else if (out_free) begin
              res_valid  = 1'b1;
              state_next = S_IDLE;
            end
          end
          FUNC_ADD: begin
            if (present) begin
              res.status = STATUS_DUP;
            end else if (!in_range || full) begin
              res.status = STATUS_FULL;
            end
            if (out_free) begin
              res_valid  = 1'b1;
              state_next = S_IDLE;
              if (res.status == STATUS_OK) begin
                add_fire    = 1'b1;
                map_we      = 1'b1;
                map_wdata   = {1'b1, SLOT_W'(count)};
                dense_we    = 1'b1;
                dense_addr  = SLOT_W'(count);
                count_next  = count + 1'b1;
                res.count   = COUNT_W'(count_next);
              end
            end
          end
          FUNC_REMOVE: begin
            if (present) begin
              // Retire the id now and fetch the last entry to fill its hole.
              map_we     = 1'b1;
              hole_next  = map_slot;
              dense_re   = 1'b1;
              dense_addr = last;
              state_next = S_DENSE;
            end else if (out_free) begin
              res.status = STATUS_ABSENT;
              res_valid  = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              res_valid  = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_DENSE: begin
        res.found = 1'b1;
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
          if (op == FUNC_REMOVE) begin
            rem_fire = 1'b1;
            if (hole != last) begin
              dense_we    = 1'b1;
              dense_addr  = hole;
              dense_wdata = dense_rdata;
              map_we      = 1'b1;
              map_addr    = moved_id;
              map_wdata   = {1'b1, hole};
            end
            count_next = count - 1'b1;
            res.count  = COUNT_W'(count_next);
          end else begin
            res.data_out = DATA_W'(moved_data);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      count   <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    id_q   <= id_q_next;
    data_q <= data_q_next;
    hole   <= hole_next;
  end

  `SST_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `SST_ASSERT_IMP(a_clear_quiet, clk, rst, state == S_CLEAR, !dense_we && !res_valid)
  `SST_ASSERT_NXT(a_add_grows, clk, rst, add_fire, count == $past(count) + 1'b1)
  `SST_ASSERT_NXT(a_rem_shrinks, clk, rst, rem_fire, count == $past(count) - 1'b1)

endmodule

// File: rtl/sparse_set_table.sv
// Top level of the sparse set table: sequencer, two memories and the response register.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_ready   sst_pkg::req_t (func, id, data_in)
//   rsp       out        rsp_valid/rsp_ready   sst_pkg::rsp_t (found, data_out, status, count)
//
// One request is worked on at a time. A lookup of a held id and a successful remove read
// the slot map and then the dense store, every other request reads only the slot map; a
// read on these single-port RAMs is registered, and the dense read waits on the map read.
// After reset all MAP_DEPTH slot map entries (1024 by default) are swept clear while
// req_ready stays low. A response waits in the output register while the next request is
// already taken; that request's final step, with its memory writes, waits until it frees.
module sparse_set_table #(
  parameter int ID_SPACE  = 1024,
  parameter int CAPACITY  = 256,
  parameter int DATA_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sst_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sst_pkg::rsp_t rsp
);
  import sst_pkg::*;

  // Ids at or above ID_SPACE can never be held, so the map only covers the reachable ids.
  localparam int MAP_DEPTH = (ID_SPACE < (1 << ID_W)) ? ID_SPACE : (1 << ID_W);
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int MAP_W     = SLOT_W + 1;
  localparam int DENSE_W   = MAP_AW + DATA_BITS;

  logic               out_free;
  logic               res_valid;
  rsp_t               res;

  logic               map_we;
  logic               map_re;
  logic [MAP_AW-1:0]  map_addr;
  logic [MAP_W-1:0]   map_wdata;
  logic [MAP_W-1:0]   map_rdata;

  logic               dense_we;
  logic               dense_re;
  logic [SLOT_W-1:0]  dense_addr;
  logic [DENSE_W-1:0] dense_wdata;
  logic [DENSE_W-1:0] dense_rdata;

  // The response register is free when empty or when its transfer completes this cycle.
  assign out_free = !rsp_valid || rsp_ready;

  sst_ctrl #(
    .ID_SPACE  (ID_SPACE),
    .CAPACITY  (CAPACITY),
    .DATA_BITS (DATA_BITS),
    .MAP_DEPTH (MAP_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .map_we      (map_we),
    .map_re      (map_re),
    .map_addr    (map_addr),
    .map_wdata   (map_wdata),
    .map_rdata   (map_rdata),
    .dense_we    (dense_we),
    .dense_re    (dense_re),
    .dense_addr  (dense_addr),
    .dense_wdata (dense_wdata),
    .dense_rdata (dense_rdata)
  );

  // Slot map: a valid flag and the dense slot of each id.
  sst_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .re    (map_re),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  // Dense store: the id and the payload held in each slot.
  sst_ram #(
    .WIDTH (DENSE_W),
    .DEPTH (CAPACITY)
  ) u_dense_ram (
    .clk   (clk),
    .we    (dense_we),
    .re    (dense_re),
    .addr  (dense_addr),
    .wdata (dense_wdata),
    .rdata (dense_rdata)
  );

  // Response register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      rsp <= res;
    end
  end

endmodule

// File: tb/sv/sst_checker.sv
// Checker for the sparse set table: predicts each response and compares it with the block.
module sst_checker #(
  parameter int CAPACITY = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  sst_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  sst_pkg::rsp_t rsp,
  output int            fail_count,
  output int            rsp_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int IDS = 2 ** ID_W;

  // Shadow copy of the table.
  logic [COUNT_W-1:0] slot_of [IDS];
  logic               held    [IDS];
  logic [ID_W-1:0]    dense_id [CAPACITY];
  logic [DATA_W-1:0]  dense_data [CAPACITY];
  int                 fill;

  rsp_t rsp_due [$];

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t sst_checker: %s", $time, msg);
  endtask

  // Applies one request to the shadow table and returns the response it should give.
  function automatic rsp_t table_apply(input req_t r);
    rsp_t               o;
    logic               hit;
    logic [COUNT_W-1:0] hole;
    logic [COUNT_W-1:0] last;
    logic [ID_W-1:0]    moved;
    hit = held[r.id] && (int'(slot_of[r.id]) < fill);
    o = '0;
    o.found = hit;
    o.status = STATUS_OK;
    case (r.func)
      FUNC_LOOKUP: begin
        if (hit) begin
          o.data_out = dense_data[slot_of[r.id]];
        end
      end
      FUNC_ADD: begin
        if (hit) begin
          o.status = STATUS_DUP;
        end else if (fill >= CAPACITY) begin
          o.status = STATUS_FULL;
        end else begin
          slot_of[r.id] = COUNT_W'(fill);
          held[r.id] = 1'b1;
          dense_id[fill] = r.id;
          dense_data[fill] = r.data_in;
          fill++;
        end
      end
      FUNC_REMOVE: begin
        if (!hit) begin
          o.status = STATUS_ABSENT;
        end else begin
          hole = slot_of[r.id];
          last = COUNT_W'(fill - 1);
          if (hole != last) begin
            moved = dense_id[last];
            slot_of[moved] = hole;
            dense_id[hole] = moved;
            dense_data[hole] = dense_data[last];
          end
          held[r.id] = 1'b0;
          fill--;
        end
      end
      default: ;
    endcase
    o.count = COUNT_W'(fill);
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      fill = 0;
      foreach (held[i]) held[i] = 1'b0;
      rsp_due.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (rsp_due.size() == 0) begin
          report_mismatch("response with nothing outstanding");
        end else begin
          want = rsp_due.pop_front();
          if (rsp.found !== want.found)
            report_mismatch($sformatf("found %0h, expected %0h", rsp.found, want.found));
          if (rsp.data_out !== want.data_out)
            report_mismatch($sformatf("data_out %0h, expected %0h",
                                      rsp.data_out, want.data_out));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", rsp.count, want.count));
        end
      end
      if (req_valid && req_ready) begin
        rsp_due.push_back(table_apply(req));
      end
    end
    rsp_owed = rsp_due.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Top of the sparse set table testbench: clock, reset, stimulus, watchdog and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  // The package names no code for the fourth operation; the block must leave the table alone.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Longest stretch without any transfer before the run is abandoned. It must outlast both
  // the slot map sweep after reset and the long receiver hold-off.
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  int fail_count;
  int rsp_owed;

  // Stimulus controls; tail and hold_asked are shared with the receiver process, which also keeps hold_done.
  bit calm;
  bit tail;
  bit hold_asked;
  bit hold_done;

  sparse_set_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  sst_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .fail_count(fail_count),
    .rsp_owed  (rsp_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one request and returns at the rising edge where its transfer takes place.
  // Unless the sender is calm, a random gap of idle cycles may come first. Everything
  // changes at the falling edge, so the block samples settled values.
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] i,
                         input logic [DATA_W-1:0] d);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= '{func: f, id: i, data_in: d};
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // Picks an operation by percentage weights; what is left over goes to the unused code.
  function automatic logic [FUNC_W-1:0] pick_func(input int w_look, input int w_add,
                                                  input int w_rem);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_look) return FUNC_LOOKUP;
    if (r < w_look + w_add) return FUNC_ADD;
    if (r < w_look + w_add + w_rem) return FUNC_REMOVE;
    return FUNC_UNUSED;
  endfunction

  // Draws an id from a window of sixteen, so that adds, hits and removes collide often.
  function automatic logic [ID_W-1:0] window_id(input logic [ID_W-1:0] base);
    return {base[ID_W-1:4], 4'($urandom_range(0, 15))};
  endfunction

  // Receiver: random bursts of back-pressure, one long hold-off on request so that the
  // block fills up and stops taking requests, and no back-pressure at all in the tail.
  initial begin
    int n;
    rsp_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      if (tail) begin
        @(negedge clk);
        rsp_ready <= 1'b1;
      end else if (hold_asked && !hold_done) begin
        @(negedge clk);
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 17);
        @(negedge clk);
        rsp_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 40);
        @(negedge clk);
        rsp_ready <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Watchdog: the run is abandoned once the quiet counter, cleared by reset and by any
  // transfer on either channel, reaches QUIET_LIMIT.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("sparse_set_table verification failed");
    $finish;
  end

  initial begin
    int              stride;
    int              start;
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] pick;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    calm = 1'b0;
    tail = 1'b0;
    hold_asked = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty table, extremes of id and payload, a duplicate add, the unused
    // operation on a held and on an absent id, and removes of both a first entry (which
    // moves the last entry into the hole) and the last entry itself.
    send_op(FUNC_LOOKUP, 10'd0, 32'h0);
    send_op(FUNC_REMOVE, 10'd1023, 32'hFFFF_FFFF);
    send_op(FUNC_ADD, 10'd0, 32'h0000_0000);
    send_op(FUNC_ADD, 10'd1023, 32'hFFFF_FFFF);
    send_op(FUNC_ADD, 10'd0, 32'h1234_5678);
    send_op(FUNC_LOOKUP, 10'd0, 32'hFFFF_FFFF);
    send_op(FUNC_LOOKUP, 10'd1023, 32'h0);
    send_op(FUNC_UNUSED, 10'd1023, $urandom);
    send_op(FUNC_UNUSED, 10'd5, $urandom);
    send_op(FUNC_REMOVE, 10'd0, 32'h0);
    send_op(FUNC_LOOKUP, 10'd1023, 32'h0);
    send_op(FUNC_REMOVE, 10'd1023, 32'h0);
    send_op(FUNC_LOOKUP, 10'd1023, 32'h0);
    send_op(FUNC_ADD, 10'd512, 32'hAAAA_AAAA);
    send_op(FUNC_ADD, 10'd341, 32'h5555_5555);
    send_op(FUNC_ADD, 10'd682, 32'h0F0F_0F0F);
    send_op(FUNC_REMOVE, 10'd512, 32'h0);
    send_op(FUNC_LOOKUP, 10'd682, 32'h0);
    send_op(FUNC_REMOVE, 10'd341, 32'h0);
    send_op(FUNC_REMOVE, 10'd682, 32'h0);
    send_op(FUNC_REMOVE, 10'd682, 32'h0);
    send_op(FUNC_LOOKUP, 10'd341, 32'h0);

    // Fill: adds of distinct ids along an odd stride. The first 256 fill the table
    // completely and the rest are refused as full.
    stride = 2 * $urandom_range(0, 511) + 1;
    start = $urandom_range(0, 1023);
    for (int k = 0; k < 300; k++) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      send_op(FUNC_ADD, ID_W'(start + k * stride), $urandom);
    end

    // Mixed traffic over the whole id space with the table near full. The receiver is
    // asked for its long hold-off here while requests keep coming.
    hold_asked = 1'b1;
    for (int k = 0; k < 400; k++) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      send_op(pick_func(35, 30, 30), ID_W'($urandom_range(0, 1023)), $urandom);
    end

    // Drain: mostly removes walking the fill stride again, with some random traffic.
    for (int k = 0; k < 300; k++) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 3) != 0) begin
        send_op(FUNC_REMOVE, ID_W'(start + k * stride), $urandom);
      end else begin
        send_op(pick_func(35, 30, 30), ID_W'($urandom_range(0, 1023)), $urandom);
      end
    end

    // Pause the sender until every outstanding response has come back.
    @(negedge clk);
    req_valid <= 1'b0;
    while (rsp_owed != 0) @(negedge clk);

    // Small windows of ids: frequent duplicates, hits and removes of every position.
    base = ID_W'($urandom);
    for (int k = 0; k < 600; k++) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      if (k % 100 == 0) base = ID_W'($urandom);
      pick = window_id(base);
      send_op(pick_func(30, 35, 30), pick, $urandom);
    end

    // Tail: the same traffic at full rate, no idling on either side.
    tail = 1'b1;
    calm = 1'b1;
    for (int k = 0; k < 300; k++) begin
      if (k % 100 == 0) base = ID_W'($urandom);
      pick = window_id(base);
      send_op(pick_func(30, 35, 30), pick, $urandom);
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (rsp_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("sparse_set_table verification clean");
    end else begin
      $display("sparse_set_table verification failed");
    end
    $finish;
  end

endmodule

// File: sparse_set_table.f
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_ram.sv
rtl/sst_ctrl.sv
rtl/sparse_set_table.sv
tb/sv/sst_checker.sv
tb/sv/tb_top.sv
